// ===== rtl/ace_pkg.sv =====
// ----------------------------------------------------------------------------
// ace_pkg
// Types and constants shared by the compute-instruction encoder modules.
// ----------------------------------------------------------------------------
package ace_pkg;

    // One input beat: a single character of the line.
    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } t_in_beat;

    // One result beat: the encoded word and the comp-too-long flag.
    typedef struct packed {
        logic [15:0] instruction;
        logic        comp_too_long;
    } t_out_beat;

    typedef enum logic [1:0] {
        PH_START     = 2'd0,
        PH_COMP      = 2'd1,
        PH_JUMP_EQ   = 2'd2,
        PH_JUMP_NOEQ = 2'd3
    } t_phase;

    localparam int unsigned COMP_DEPTH = 4;
    localparam int unsigned JUMP_DEPTH = 3;

    // Running state of the line being parsed.
    typedef struct packed {
        t_phase                phase;
        logic [2:0]            dest_flags;
        logic [3:0][7:0]       comp_chars;
        logic [2:0]            comp_count;
        logic                  comp_overflow;
        logic [2:0][7:0]       jump_chars;
        logic [2:0]            jump_count;
    } t_seg;

    // ASCII characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam logic [2:0] C_PREFIX = 3'b111;

    // Comp field codes (without the a-bit)
    localparam logic [5:0] COMP_ZERO    = 6'b101010;
    localparam logic [5:0] COMP_ONE     = 6'b111111;
    localparam logic [5:0] COMP_NEG_ONE = 6'b111010;
    localparam logic [5:0] COMP_AND     = 6'b000000;
    localparam logic [5:0] COMP_OR      = 6'b010101;
    localparam logic [5:0] COMP_A       = 6'b110000;
    localparam logic [5:0] COMP_NOT_A   = 6'b110001;
    localparam logic [5:0] COMP_NEG_A   = 6'b110011;
    localparam logic [5:0] COMP_A_DEC   = 6'b110010;
    localparam logic [5:0] COMP_A_INC   = 6'b110111;
    localparam logic [5:0] COMP_D       = 6'b001100;
    localparam logic [5:0] COMP_NOT_D   = 6'b001101;
    localparam logic [5:0] COMP_NEG_D   = 6'b001111;
    localparam logic [5:0] COMP_D_DEC   = 6'b001110;
    localparam logic [5:0] COMP_D_INC   = 6'b011111;
    localparam logic [5:0] COMP_D_SUB_A = 6'b010011;
    localparam logic [5:0] COMP_A_SUB_D = 6'b000111;
    localparam logic [5:0] COMP_D_ADD_A = 6'b000010;

    // Jump field codes
    localparam logic [2:0] JMP_NONE = 3'd0;
    localparam logic [2:0] JMP_JGT  = 3'd1;
    localparam logic [2:0] JMP_JEQ  = 3'd2;
    localparam logic [2:0] JMP_JGE  = 3'd3;
    localparam logic [2:0] JMP_JLT  = 3'd4;
    localparam logic [2:0] JMP_JNE  = 3'd5;
    localparam logic [2:0] JMP_JLE  = 3'd6;
    localparam logic [2:0] JMP_JMP  = 3'd7;

endpackage

// ===== rtl/assembly_compute_instruction_encoder.sv =====
// ----------------------------------------------------------------------------
// assembly_compute_instruction_encoder
// Encodes one compute-instruction line, streamed a character per beat, into
// the 16-bit word 111a cccccc ddd jjj.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one ASCII character per beat; last_symbol marks
//   the final character of a line. Only the final beat of a line produces a
//   result beat on the output channel, carrying the encoded word and a flag
//   that is set when the comp text ran past four characters.
//   A beat is registered in the input register on acceptance, parsed from
//   there by the parse stage, and the result is loaded into the output
//   register; a final character waits in the input register only while a
//   stalled earlier result still holds the output register.
//   Throughput is one character per cycle while the input is not stalled,
//   set by the single parse stage between the input and output registers.
//   When the receiver stalls, the result waits in the output register and
//   the input register may still take one more beat; non-final characters
//   keep flowing, and input stalls only when a final character finds the
//   output register full and stalled.
//   Reset clears all valid flags and returns the parser to the start of a
//   line.
// ----------------------------------------------------------------------------
module assembly_compute_instruction_encoder import ace_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    logic      r_s1_valid;
    t_in_beat  r_s1;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      w_out_free;
    logic      w_step;
    t_seg      w_next;
    t_out_beat w_word;

    assign w_out_free = !r_out_valid || !i_out_stall;
    // Non-final beats never need the output register.
    assign w_step     = r_s1_valid && (!r_s1.last_symbol || w_out_free);
    assign o_in_stall = r_s1_valid && !w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1 <= i_in;
        end
    end

    ace_segment u_segment (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_beat  (r_s1),
        .o_next  (w_next)
    );

    ace_word_encode u_encode (
        .i_seg  (w_next),
        .o_word (w_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && r_s1.last_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_step && r_s1.last_symbol) begin
            r_out <= w_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_line_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_s1.last_symbol) |=> o_out_valid)
        else $error("final beat of a line did not produce a result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_step && r_s1.last_symbol))
        else $error("result appeared without a final beat");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1.last_symbol && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked final beat");

endmodule

// ===== rtl/ace_segment.sv =====
// ----------------------------------------------------------------------------
// ace_segment
// Tracks the dest, comp and jump segments of the current line and presents
// the state as it stands after the beat being processed.
// ----------------------------------------------------------------------------
module ace_segment import ace_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_beat i_beat,
    output t_seg     o_next
);

    t_seg   r_seg;
    t_seg   n_seg;
    t_phase n_phase;
    logic   w_live;
    logic   w_put_comp;
    logic   w_put_jump;
    logic   w_open_comp;
    logic   w_dest;

    assign w_live = (i_beat.symbol != CH_NUL);

    // Next phase
    always_comb begin
        n_phase = r_seg.phase;
        if (w_live) begin
            case (r_seg.phase)
                PH_START: begin
                    if (i_beat.symbol == CH_EQ) begin
                        n_phase = PH_COMP;
                    end else if (i_beat.symbol == CH_SEMI) begin
                        n_phase = PH_JUMP_NOEQ;
                    end
                end
                PH_COMP: begin
                    if (i_beat.symbol == CH_SEMI) begin
                        n_phase = PH_JUMP_EQ;
                    end
                end
                default: n_phase = r_seg.phase;
            endcase
        end
    end

    // Actions taken by the current phase
    always_comb begin
        w_put_comp  = 1'b0;
        w_put_jump  = 1'b0;
        w_open_comp = 1'b0;
        w_dest      = 1'b0;
        if (w_live) begin
            case (r_seg.phase)
                PH_START: begin
                    if (i_beat.symbol == CH_EQ) begin
                        w_open_comp = 1'b1;
                    end else if (i_beat.symbol != CH_SEMI) begin
                        w_dest     = 1'b1;
                        w_put_comp = 1'b1;
                    end
                end
                PH_COMP: begin
                    w_put_comp = (i_beat.symbol != CH_SEMI);
                end
                PH_JUMP_EQ, PH_JUMP_NOEQ: begin
                    w_put_jump = 1'b1;
                end
                default: w_put_jump = 1'b0;
            endcase
        end
    end

    // Segment data
    always_comb begin
        n_seg       = r_seg;
        n_seg.phase = n_phase;
        if (w_dest) begin
            if (i_beat.symbol == CH_A) n_seg.dest_flags[2] = 1'b1;
            if (i_beat.symbol == CH_D) n_seg.dest_flags[1] = 1'b1;
            if (i_beat.symbol == CH_M) n_seg.dest_flags[0] = 1'b1;
        end
        if (w_open_comp) begin
            n_seg.comp_count    = 3'd0;
            n_seg.comp_overflow = 1'b0;
        end
        if (w_put_comp) begin
            if (r_seg.comp_count < 3'(COMP_DEPTH)) begin
                n_seg.comp_chars[r_seg.comp_count[1:0]] = i_beat.symbol;
                n_seg.comp_count = r_seg.comp_count + 3'd1;
            end else begin
                n_seg.comp_overflow = 1'b1;
            end
        end
        if (w_put_jump) begin
            if (r_seg.jump_count < 3'(JUMP_DEPTH)) begin
                n_seg.jump_chars[r_seg.jump_count[1:0]] = i_beat.symbol;
            end
            // Count saturates one past the store so long mnemonics never match.
            if (r_seg.jump_count <= 3'(JUMP_DEPTH)) begin
                n_seg.jump_count = r_seg.jump_count + 3'd1;
            end
        end
    end

    assign o_next = n_seg;

    // Control fields; a finished line returns to the start state.
    // Character stores are only read below their fill counts and are not reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.phase         <= PH_START;
            r_seg.dest_flags    <= 3'd0;
            r_seg.comp_count    <= 3'd0;
            r_seg.comp_overflow <= 1'b0;
            r_seg.jump_count    <= 3'd0;
        end else if (i_step) begin
            r_seg.comp_chars <= n_seg.comp_chars;
            r_seg.jump_chars <= n_seg.jump_chars;
            if (i_beat.last_symbol) begin
                r_seg.phase         <= PH_START;
                r_seg.dest_flags    <= 3'd0;
                r_seg.comp_count    <= 3'd0;
                r_seg.comp_overflow <= 1'b0;
                r_seg.jump_count    <= 3'd0;
            end else begin
                r_seg.phase         <= n_seg.phase;
                r_seg.dest_flags    <= n_seg.dest_flags;
                r_seg.comp_count    <= n_seg.comp_count;
                r_seg.comp_overflow <= n_seg.comp_overflow;
                r_seg.jump_count    <= n_seg.jump_count;
            end
        end
    end

endmodule

// ===== rtl/ace_word_encode.sv =====
// ----------------------------------------------------------------------------
// ace_word_encode
// Decodes the comp, dest and jump segments of a finished line into the
// 16-bit compute word.
// ----------------------------------------------------------------------------
module ace_word_encode import ace_pkg::*; (
    input  t_seg      i_seg,
    output t_out_beat o_word
);

    function automatic logic is_text(
        input logic [3:0][7:0] buf_chars,
        input logic [2:0]      len,
        input logic [2:0]      want_len,
        input logic [7:0]      c0,
        input logic [7:0]      c1,
        input logic [7:0]      c2
    );
        logic hit;
        hit = (len == want_len);
        if (want_len >= 3'd1) hit = hit && (buf_chars[0] == c0);
        if (want_len >= 3'd2) hit = hit && (buf_chars[1] == c1);
        if (want_len >= 3'd3) hit = hit && (buf_chars[2] == c2);
        return hit;
    endfunction

    logic [3:0][7:0] w_orig;
    logic [3:0][7:0] w_fixed;
    logic [3:0]      w_used;
    logic [2:0]      w_len;
    logic            w_a_bit;
    logic            w_has_amp;
    logic            w_has_bar;
    logic            w_has_a;
    logic            w_has_d;
    logic [5:0]      w_comp;
    logic [2:0]      w_dest;
    logic [2:0]      w_jump;

    assign w_orig = i_seg.comp_chars;
    assign w_len  = i_seg.comp_count;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_used[i] = (3'(i) < w_len);
        end
    end

    // The first M becomes A and selects the memory operand.
    always_comb begin
        w_fixed = w_orig;
        w_a_bit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (!w_a_bit && w_used[i] && (w_orig[i] == CH_M)) begin
                w_fixed[i] = CH_A;
                w_a_bit    = 1'b1;
            end
        end
    end

    always_comb begin
        w_has_amp = 1'b0;
        w_has_bar = 1'b0;
        w_has_a   = 1'b0;
        w_has_d   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_has_amp = w_has_amp | (w_used[i] & (w_fixed[i] == CH_AMP));
            w_has_bar = w_has_bar | (w_used[i] & (w_fixed[i] == CH_BAR));
            w_has_a   = w_has_a   | (w_used[i] & (w_fixed[i] == CH_A));
            w_has_d   = w_has_d   | (w_used[i] & (w_fixed[i] == CH_D));
        end
    end

    // Rules are tried in priority order; the first hit wins.
    always_comb begin
        if (is_text(w_orig, w_len, 3'd1, CH_ZERO, CH_NUL, CH_NUL)) begin
            w_comp = COMP_ZERO;
        end else if (is_text(w_orig, w_len, 3'd1, CH_ONE, CH_NUL, CH_NUL)) begin
            w_comp = COMP_ONE;
        end else if (is_text(w_orig, w_len, 3'd2, CH_MINUS, CH_ONE, CH_NUL)) begin
            w_comp = COMP_NEG_ONE;
        end else if (w_has_amp) begin
            w_comp = COMP_AND;
        end else if (w_has_bar) begin
            w_comp = COMP_OR;
        end else if (w_has_a && !w_has_d) begin
            if (is_text(w_fixed, w_len, 3'd1, CH_A, CH_NUL, CH_NUL)) begin
                w_comp = COMP_A;
            end else if (is_text(w_fixed, w_len, 3'd2, CH_BANG, CH_A, CH_NUL)) begin
                w_comp = COMP_NOT_A;
            end else if (is_text(w_fixed, w_len, 3'd2, CH_MINUS, CH_A, CH_NUL)) begin
                w_comp = COMP_NEG_A;
            end else if (is_text(w_fixed, w_len, 3'd3, CH_A, CH_MINUS, CH_ONE)) begin
                w_comp = COMP_A_DEC;
            end else begin
                w_comp = COMP_A_INC;
            end
        end else if (w_has_d && !w_has_a) begin
            if (is_text(w_fixed, w_len, 3'd1, CH_D, CH_NUL, CH_NUL)) begin
                w_comp = COMP_D;
            end else if (is_text(w_fixed, w_len, 3'd2, CH_BANG, CH_D, CH_NUL)) begin
                w_comp = COMP_NOT_D;
            end else if (is_text(w_fixed, w_len, 3'd2, CH_MINUS, CH_D, CH_NUL)) begin
                w_comp = COMP_NEG_D;
            end else if (is_text(w_fixed, w_len, 3'd3, CH_D, CH_MINUS, CH_ONE)) begin
                w_comp = COMP_D_DEC;
            end else begin
                w_comp = COMP_D_INC;
            end
        end else if (is_text(w_fixed, w_len, 3'd3, CH_D, CH_MINUS, CH_A)) begin
            w_comp = COMP_D_SUB_A;
        end else if (is_text(w_fixed, w_len, 3'd3, CH_A, CH_MINUS, CH_D)) begin
            w_comp = COMP_A_SUB_D;
        end else begin
            w_comp = COMP_D_ADD_A;
        end
    end

    // Jump mnemonic, exactly three characters
    always_comb begin
        w_jump = JMP_NONE;
        if (i_seg.jump_count == 3'(JUMP_DEPTH) && i_seg.jump_chars[0] == CH_J) begin
            case ({i_seg.jump_chars[1], i_seg.jump_chars[2]})
                {CH_G, CH_T}: w_jump = JMP_JGT;
                {CH_E, CH_Q}: w_jump = JMP_JEQ;
                {CH_G, CH_E}: w_jump = JMP_JGE;
                {CH_L, CH_T}: w_jump = JMP_JLT;
                {CH_N, CH_E}: w_jump = JMP_JNE;
                {CH_L, CH_E}: w_jump = JMP_JLE;
                {CH_M, CH_P}: w_jump = JMP_JMP;
                default:      w_jump = JMP_NONE;
            endcase
        end
    end

    // Dest letters only count when an '=' was seen.
    assign w_dest = (i_seg.phase == PH_COMP || i_seg.phase == PH_JUMP_EQ)
                    ? i_seg.dest_flags : 3'd0;

    assign o_word.instruction   = {C_PREFIX, w_a_bit, w_comp, w_dest, w_jump};
    assign o_word.comp_too_long = i_seg.comp_overflow;

endmodule
